### rtl/mmf_pkg.sv
// ============================================================================
// MIDI message filter package
// Shared types, constants and the event-length lookup for the MIDI filter.
// ============================================================================
package mmf_pkg;

    // Fixed channel count and default ring size per channel.
    localparam int CHANNELS  = 16;
    localparam int NOTES_DEF = 8;
    localparam int MAX_NOTES = 16;

    // Widths of the note index and the note count on the controller link.
    localparam int IDX_W     = $clog2(MAX_NOTES);
    localparam int RUN_CNT_W = $clog2(MAX_NOTES + 1);

    // Byte codes.
    localparam logic [7:0] REALTIME_MIN  = 8'hF8;
    localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
    localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
    localparam logic [3:0] KIND_CTRL     = 4'hB;
    localparam logic [7:0] CC_ALL_OFF_LO = 8'h7B;
    localparam logic [7:0] CC_ALL_OFF_HI = 8'h7F;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RAW,
        ST_MSG,
        ST_NOFF
    } t_state;

    // What an accepted byte asks for.
    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_RAW,
        ACT_MSG,
        ACT_NOFF
    } t_action;

    // Source of the next output byte.
    typedef enum logic [2:0] {
        SEL_BYTE,
        SEL_STATUS,
        SEL_FIRST,
        SEL_SECOND,
        SEL_NOFF,
        SEL_NOTE,
        SEL_ZERO
    } t_sel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             accept;
        logic             load;
        t_sel             sel;
        logic             last;
        logic             rd_en;
        logic [IDX_W-1:0] rd_idx;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_action              action;
        logic                 out_free;
        logic [1:0]           msg_len;
        logic [RUN_CNT_W-1:0] run_cnt;
    } t_sts;

    // Message length of a status byte from the fixed event-length table.
    function automatic logic [1:0] mmf_len(input logic [7:0] s);
        logic [1:0] len;
        case (s) inside
            [8'h80:8'hBF]: len = 2'd3;
            [8'hC0:8'hDF]: len = 2'd2;
            [8'hE0:8'hEF]: len = 2'd3;
            8'hF1:         len = 2'd2;
            8'hF2:         len = 2'd3;
            8'hF3:         len = 2'd2;
            8'hF6:         len = 2'd1;
            default:       len = 2'd0;
        endcase
        return len;
    endfunction

endpackage

### rtl/mmf_in_if.sv
// ============================================================================
// MIDI filter input channel
// Valid/ready channel that carries one raw MIDI byte per transfer.
// ============================================================================
interface mmf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

### rtl/mmf_out_if.sv
// ============================================================================
// MIDI filter output channel
// Valid/ready channel that carries one MIDI byte and its end-of-run flag.
// ============================================================================
interface mmf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_out;
    logic       last_of_run;

    modport source (output valid, output byte_out, output last_of_run, input ready);
    modport sink   (input valid, input byte_out, input last_of_run, output ready);
endinterface

### rtl/mmf_cfg_if.sv
// ============================================================================
// MIDI filter configuration channel
// Valid/ready write channel for the note-tracking enable register.
// ============================================================================
interface mmf_cfg_if;
    logic valid;
    logic ready;
    logic emulate_all_notes_off;

    modport source (output valid, output emulate_all_notes_off, input ready);
    modport sink   (input valid, input emulate_all_notes_off, output ready);
endinterface

### rtl/mmf_ctrl.sv
// ============================================================================
// MIDI filter controller
// State machine that accepts bytes and sequences the output bytes of a run.
// ============================================================================
module mmf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  mmf_pkg::t_sts i_sts,
    output mmf_pkg::t_cmd o_cmd
);
    import mmf_pkg::*;

    t_state                r_state, n_state;
    logic [1:0]            r_pos;
    logic [1:0]            r_phase;
    logic [IDX_W-1:0]      r_idx;
    logic                  w_accept;
    logic                  w_last_msg;
    logic                  w_last_note;

    // A byte is taken only between runs.
    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_last_msg  = (r_pos == i_sts.msg_len - 2'd1);
    assign w_last_note = (RUN_CNT_W'(r_idx) == i_sts.run_cnt - RUN_CNT_W'(1));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_sts.action)
                        ACT_RAW:  n_state = ST_RAW;
                        ACT_MSG:  n_state = ST_MSG;
                        ACT_NOFF: n_state = ST_NOFF;
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_RAW: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            ST_MSG: begin
                if (i_sts.out_free && w_last_msg) n_state = ST_IDLE;
            end
            ST_NOFF: begin
                if (i_sts.out_free && r_phase == 2'd2 && w_last_note) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd        = '0;
        o_cmd.accept = w_accept;
        o_cmd.sel    = SEL_BYTE;
        o_cmd.rd_idx = r_idx;
        case (r_state)
            ST_RAW: begin
                o_cmd.load = i_sts.out_free;
                o_cmd.sel  = SEL_BYTE;
                o_cmd.last = 1'b1;
            end
            ST_MSG: begin
                o_cmd.load = i_sts.out_free;
                o_cmd.last = w_last_msg;
                case (r_pos)
                    2'd0:    o_cmd.sel = SEL_STATUS;
                    2'd1:    o_cmd.sel = SEL_FIRST;
                    default: o_cmd.sel = SEL_SECOND;
                endcase
            end
            ST_NOFF: begin
                o_cmd.load = i_sts.out_free;
                case (r_phase)
                    2'd0: begin
                        o_cmd.sel   = SEL_NOFF;
                        o_cmd.rd_en = i_sts.out_free;
                    end
                    2'd1: o_cmd.sel = SEL_NOTE;
                    default: begin
                        o_cmd.sel  = SEL_ZERO;
                        o_cmd.last = w_last_note;
                    end
                endcase
            end
            default: o_cmd.load = 1'b0;
        endcase
    end

    // State and run counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pos   <= '0;
            r_phase <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_MSG && i_sts.out_free) begin
                r_pos <= w_last_msg ? 2'd0 : r_pos + 2'd1;
            end
            if (r_state == ST_NOFF && i_sts.out_free) begin
                if (r_phase == 2'd2) begin
                    r_phase <= 2'd0;
                    r_idx   <= w_last_note ? '0 : r_idx + IDX_W'(1);
                end else begin
                    r_phase <= r_phase + 2'd1;
                end
            end
        end
    end

    // A byte is loaded only into a free output register.
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> i_sts.out_free)
        else $error("output byte loaded while the output register was busy");

    // A note-off run always has at least one tracked note.
    a_noff_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_NOFF) |-> (i_sts.run_cnt != '0))
        else $error("note-off run started with no tracked notes");

    // A completed message leads straight into its emission.
    a_msg_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_sts.action == ACT_MSG) |=> (r_state == ST_MSG && r_pos == 2'd0))
        else $error("message emission did not start after completion");

endmodule

### rtl/mmf_datapath.sv
// ============================================================================
// MIDI filter datapath
// Parser registers, per-channel note rings, note memory and output register.
// ============================================================================
module mmf_datapath #(
    parameter int NOTES_PER_CHANNEL = mmf_pkg::NOTES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [7:0]    i_byte,
    input  logic          i_cfg_we,
    input  logic          i_cfg_data,
    input  mmf_pkg::t_cmd i_cmd,
    output mmf_pkg::t_sts o_sts,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output logic [7:0]    o_out_byte,
    output logic          o_out_last
);
    import mmf_pkg::*;

    localparam int SLOT_W = (NOTES_PER_CHANNEL > 1) ? $clog2(NOTES_PER_CHANNEL) : 1;
    localparam int CNT_W  = $clog2(NOTES_PER_CHANNEL + 1);
    localparam int DEPTH  = CHANNELS * NOTES_PER_CHANNEL;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [ADDR_W-1:0] NOTES_A = ADDR_W'(NOTES_PER_CHANNEL);

    // Parser and configuration registers.
    logic             r_emulate;
    logic [7:0]       r_status;
    logic [1:0]       r_len;
    logic [1:0]       r_pos;
    logic [7:0]       r_first;
    logic [7:0]       r_second;
    logic [7:0]       r_byte;
    logic [CNT_W-1:0] r_run_cnt;

    // Per-channel note rings.
    logic [CNT_W-1:0]  r_notes_in_use [CHANNELS];
    logic [SLOT_W-1:0] r_next_slot    [CHANNELS];
    logic [6:0]        r_mem          [DEPTH];
    logic [6:0]        r_rd_data;

    // Output register.
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;
    logic [7:0] w_out_byte;

    // Parse of the incoming byte.
    logic              w_is_rt;
    logic              w_is_status;
    logic [7:0]        n_status;
    logic [1:0]        n_len;
    logic [1:0]        w_pos_base;
    logic [1:0]        w_pos_inc;
    logic [7:0]        n_first;
    logic [7:0]        n_second;
    logic              w_complete;
    logic [3:0]        w_ch;
    logic [3:0]        w_kind;
    logic [CNT_W-1:0]  w_cnt;
    logic [SLOT_W-1:0] w_slot;
    logic [SLOT_W-1:0] w_slot_nxt;
    logic              w_note_on;
    logic              w_all_off;
    logic              w_msg_done;
    logic              w_record;
    logic              w_clear;
    logic [ADDR_W-1:0] w_wr_addr;
    logic [ADDR_W-1:0] w_rd_addr;
    t_action           w_action;

    assign w_is_rt     = (i_byte >= REALTIME_MIN);
    assign w_is_status = i_byte[7];
    assign n_status    = w_is_status ? i_byte : r_status;
    assign n_len       = w_is_status ? mmf_len(i_byte) : r_len;
    assign w_pos_base  = w_is_status ? 2'd0 : r_pos;
    assign w_pos_inc   = w_pos_base + 2'd1;
    assign n_first     = (w_pos_base == 2'd1) ? i_byte : r_first;
    assign n_second    = (w_pos_base == 2'd2) ? i_byte : r_second;
    assign w_complete  = (w_pos_inc >= n_len);
    assign w_ch        = n_status[3:0];
    assign w_kind      = n_status[7:4];
    assign w_cnt       = r_notes_in_use[w_ch];

    // Ring slot for a new note, wrapping at the ring size.
    always_comb begin
        w_slot = r_next_slot[w_ch];
        if (int'(w_slot) >= NOTES_PER_CHANNEL) w_slot = '0;
        w_slot_nxt = (int'(w_slot) == NOTES_PER_CHANNEL - 1) ? '0 : w_slot + SLOT_W'(1);
    end

    // Classification of a completed message.
    assign w_note_on  = r_emulate && (w_kind == KIND_NOTE_ON);
    assign w_all_off  = r_emulate && (w_kind == KIND_CTRL) &&
                        (n_first >= CC_ALL_OFF_LO) && (n_first <= CC_ALL_OFF_HI);
    assign w_msg_done = i_cmd.accept && !w_is_rt && (n_len != 2'd0) && w_complete;
    assign w_record   = w_msg_done && w_note_on && (n_second != 8'd0);
    assign w_clear    = w_msg_done && w_all_off;

    always_comb begin
        if (w_is_rt || n_len == 2'd0) begin
            w_action = ACT_RAW;
        end else if (!w_complete) begin
            w_action = ACT_NONE;
        end else if (w_all_off && !w_note_on) begin
            w_action = (w_cnt != '0) ? ACT_NOFF : ACT_NONE;
        end else begin
            w_action = ACT_MSG;
        end
    end

    // Status to the controller.
    assign o_sts.action   = w_action;
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_sts.msg_len  = r_len;
    assign o_sts.run_cnt  = RUN_CNT_W'(r_run_cnt);

    // Parser state and channel ring bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emulate <= 1'b0;
            r_status  <= '0;
            r_len     <= '0;
            r_pos     <= '0;
            r_first   <= '0;
            r_second  <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_notes_in_use[i] <= '0;
                r_next_slot[i]    <= '0;
            end
        end else begin
            if (i_cfg_we) r_emulate <= i_cfg_data;
            if (i_cmd.accept && !w_is_rt) begin
                r_status <= n_status;
                r_len    <= n_len;
                if (n_len != 2'd0) begin
                    r_first  <= n_first;
                    r_second <= n_second;
                    r_pos    <= w_complete ? 2'd1 : w_pos_inc;
                end else begin
                    r_pos <= w_pos_base;
                end
            end
            if (w_record) begin
                r_next_slot[w_ch] <= w_slot_nxt;
                if (int'(w_cnt) < NOTES_PER_CHANNEL) begin
                    r_notes_in_use[w_ch] <= w_cnt + CNT_W'(1);
                end
            end else if (w_clear) begin
                r_next_slot[w_ch]    <= '0;
                r_notes_in_use[w_ch] <= '0;
            end
        end
    end

    // Accepted byte and note count captured for the run.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_byte    <= i_byte;
            r_run_cnt <= w_cnt;
        end
    end

    // Note memory: one write port, one registered read port.
    assign w_wr_addr = ADDR_W'(w_ch) * NOTES_A + ADDR_W'(w_slot);
    assign w_rd_addr = ADDR_W'(r_status[3:0]) * NOTES_A +
                       ADDR_W'(i_cmd.rd_idx[SLOT_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (w_record) r_mem[w_wr_addr] <= n_first[6:0];
        if (i_cmd.rd_en) r_rd_data <= r_mem[w_rd_addr];
    end

    // Output byte selection.
    always_comb begin
        case (i_cmd.sel)
            SEL_BYTE:   w_out_byte = r_byte;
            SEL_STATUS: w_out_byte = r_status;
            SEL_FIRST:  w_out_byte = r_first;
            SEL_SECOND: w_out_byte = r_second;
            SEL_NOFF:   w_out_byte = {KIND_NOTE_OFF, r_status[3:0]};
            SEL_NOTE:   w_out_byte = {1'b0, r_rd_data};
            default:    w_out_byte = 8'd0;
        endcase
    end

    // Output register; holds its byte while the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_byte <= w_out_byte;
            r_out_last <= i_cmd.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;

    // A loaded byte is offered in the following cycle.
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> r_out_valid)
        else $error("loaded output byte was not offered");

    // The count of tracked notes never exceeds the ring size.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(w_cnt) <= NOTES_PER_CHANNEL)
        else $error("tracked note count beyond ring size");

    // Memory reads happen only while a note-off header byte is loaded.
    a_rd_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_en |-> (i_cmd.load && i_cmd.sel == SEL_NOFF))
        else $error("note memory read outside a note-off header");

endmodule

### rtl/midi_message_filter_note_tracking_top.sv
// ============================================================================
// MIDI message filter with note tracking
// Top level: running-status parser with per-channel note tracking.
// ============================================================================
// Usage:
// i_in carries one MIDI byte per transfer; o_out returns the resulting bytes,
// with last_of_run set on the final byte caused by one input byte. Some input
// bytes cause no output at all (incomplete messages, or an all-notes-off with
// nothing tracked). i_cfg writes the emulation enable and is always ready. The
// user must see that it is written only while the block is idle; the block
// itself does not enforce this.
// The first result of a byte is loaded into the output register, once that
// register is free, from the run state the transfer starts. A byte holds the
// controller until all its result bytes are loaded: one for a pass-through
// byte, the message length for a message, and three per tracked note for a
// synthesized note-off run. When the receiver stalls, the output register
// holds its byte and the run pauses; a new input byte is taken once the last
// result of the run sits in the output register, even before it is taken.
// Reset clears the parser, the enable and every channel's note count; the
// note memory itself needs no clearing.
// ============================================================================
module midi_message_filter_note_tracking_top #(
    parameter int NOTES_PER_CHANNEL = mmf_pkg::NOTES_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    mmf_in_if.sink     i_in,
    mmf_out_if.source  o_out,
    mmf_cfg_if.sink    i_cfg
);
    import mmf_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // Configuration writes are always taken.
    assign i_cfg.ready = 1'b1;

    // Controller.
    mmf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Datapath.
    mmf_datapath #(
        .NOTES_PER_CHANNEL (NOTES_PER_CHANNEL)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte      (i_in.byte_in),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_data  (i_cfg.emulate_all_notes_off),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_out_byte  (o_out.byte_out),
        .o_out_last  (o_out.last_of_run)
    );

endmodule

### verif/mmf_note_checker.sv
// ============================================================================
// MIDI filter scoreboard
// Watches the input, output and configuration channels of the MIDI filter.
// Every accepted input byte is run through a running-status parser with
// per-channel note rings. The parser queues the bytes that the filter should
// send. Each output transfer is compared against the oldest queued byte.
// ============================================================================
module mmf_note_checker #(
    parameter int NOTES_PER_CHANNEL = mmf_pkg::NOTES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    mmf_in_if    i_in,
    mmf_out_if   i_out,
    mmf_cfg_if   i_cfg,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import mmf_pkg::*;

    // Upper nibbles and system nibbles that decide a message length.
    localparam logic [3:0] KIND_PROGRAM  = 4'hC;
    localparam logic [3:0] KIND_PRESSURE = 4'hD;
    localparam logic [3:0] KIND_SYSTEM   = 4'hF;
    localparam logic [3:0] SYS_MTC       = 4'h1;
    localparam logic [3:0] SYS_SONG_POS  = 4'h2;
    localparam logic [3:0] SYS_SONG_SEL  = 4'h3;
    localparam logic [3:0] SYS_TUNE      = 4'h6;

    typedef struct packed {
        logic [7:0] midi_byte;
        logic       run_end;
    } t_midi_out;

    // Parser state as the filter should hold it.
    logic       emulate_on;
    logic [7:0] run_status;
    logic [1:0] msg_len;
    logic [1:0] msg_pos;
    logic [7:0] data1;
    logic [7:0] data2;
    logic [6:0] note_ring [CHANNELS][NOTES_PER_CHANNEL];
    int         ring_count [CHANNELS];
    int         ring_next [CHANNELS];

    t_midi_out  expected_bytes[$];
    t_midi_out  oldest;
    int         mismatches;

    // Length of a message from its status byte (bit 7 is always set here).
    function automatic logic [1:0] event_length(input logic [7:0] status);
        logic [1:0] len;
        if (status[7:4] == KIND_PROGRAM || status[7:4] == KIND_PRESSURE) begin
            len = 2'd2;
        end else if (status[7:4] != KIND_SYSTEM) begin
            len = 2'd3;
        end else begin
            case (status[3:0])
                SYS_MTC, SYS_SONG_SEL: len = 2'd2;
                SYS_SONG_POS:          len = 2'd3;
                SYS_TUNE:              len = 2'd1;
                default:               len = 2'd0;
            endcase
        end
        return len;
    endfunction

    task automatic queue_byte(input logic [7:0] value);
        expected_bytes.push_back('{midi_byte: value, run_end: 1'b0});
    endtask

    // Re-emit the held message with as many data bytes as its length calls for.
    task automatic queue_message();
        queue_byte(run_status);
        if (msg_len >= 2'd2) queue_byte(data1);
        if (msg_len >= 2'd3) queue_byte(data2);
    endtask

    // Work out the bytes that one input byte causes and queue them.
    task automatic parse_midi_byte(input logic [7:0] value);
        int         size_before;
        int         slot;
        int         n;
        logic [3:0] chan;
        t_midi_out  tail;
        size_before = expected_bytes.size();
        if (value >= REALTIME_MIN) begin
            queue_byte(value);
        end else begin
            if (value[7]) begin
                run_status = value;
                msg_pos    = 2'd0;
                msg_len    = event_length(value);
            end
            if (msg_len == 2'd0) begin
                queue_byte(value);
            end else begin
                if (msg_pos == 2'd1) data1 = value;
                else if (msg_pos == 2'd2) data2 = value;
                msg_pos = msg_pos + 2'd1;
                if (msg_pos >= msg_len) begin
                    chan = run_status[3:0];
                    if (emulate_on && run_status[7:4] == KIND_NOTE_ON) begin
                        // Only sounding notes go into the channel's ring.
                        if (data2 != 8'd0) begin
                            slot = ring_next[chan];
                            if (slot >= NOTES_PER_CHANNEL) slot = 0;
                            note_ring[chan][slot] = data1[6:0];
                            slot++;
                            if (slot >= NOTES_PER_CHANNEL) slot = 0;
                            ring_next[chan] = slot;
                            if (ring_count[chan] < NOTES_PER_CHANNEL) ring_count[chan]++;
                        end
                        queue_message();
                    end else if (emulate_on && run_status[7:4] == KIND_CTRL &&
                                 data1 >= CC_ALL_OFF_LO && data1 <= CC_ALL_OFF_HI) begin
                        // All-notes-off becomes one note-off per tracked note.
                        for (n = 0; n < ring_count[chan]; n++) begin
                            queue_byte({KIND_NOTE_OFF, chan});
                            queue_byte({1'b0, note_ring[chan][n]});
                            queue_byte(8'h00);
                        end
                        ring_count[chan] = 0;
                        ring_next[chan]  = 0;
                    end else begin
                        queue_message();
                    end
                    msg_pos = 2'd1;
                end
            end
        end
        // Flag the final byte of this run.
        if (expected_bytes.size() > size_before) begin
            tail = expected_bytes.pop_back();
            tail.run_end = 1'b1;
            expected_bytes.push_back(tail);
        end
    endtask

    // Compare output transfers first, then apply configuration and input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            emulate_on = 1'b0;
            run_status = 8'd0;
            msg_len    = 2'd0;
            msg_pos    = 2'd0;
            data1      = 8'd0;
            data2      = 8'd0;
            mismatches = 0;
            for (int c = 0; c < CHANNELS; c++) begin
                ring_count[c] = 0;
                ring_next[c]  = 0;
            end
            expected_bytes.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                if (expected_bytes.size() == 0) begin
                    $display("%0t: unexpected output, expected nothing, got byte %02h last %0b",
                             $time, i_out.byte_out, i_out.last_of_run);
                    mismatches++;
                end else begin
                    oldest = expected_bytes.pop_front();
                    if (oldest.midi_byte !== i_out.byte_out) begin
                        $display("%0t: byte_out mismatch, expected %02h, got %02h",
                                 $time, oldest.midi_byte, i_out.byte_out);
                        mismatches++;
                    end
                    if (oldest.run_end !== i_out.last_of_run) begin
                        $display("%0t: last_of_run mismatch, expected %0b, got %0b",
                                 $time, oldest.run_end, i_out.last_of_run);
                        mismatches++;
                    end
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                emulate_on = i_cfg.emulate_all_notes_off;
            end
            if (i_in.valid && i_in.ready) begin
                parse_midi_byte(i_in.byte_in);
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_bytes.size();
    end

endmodule

### verif/tb_top.sv
// ============================================================================
// MIDI filter testbench
// Drives MIDI bytes into the filter: a directed sequence first, then random
// well-formed messages mixed with noise and broken messages. The sender and
// the receiver idle at random, and the receiver holds off once for a long
// stretch. The emulation enable is switched between phases while the filter
// is idle. The scoreboard counts the mismatches, and this module gives the
// verdict.
// ============================================================================
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mmf_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int HOLD_CYCLES    = 60;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DIRECTED_LEN   = 29;

    // Range starts used to pick the number of data bytes of a channel message.
    localparam logic [7:0] PROGRAM_FIRST = 8'hC0;
    localparam logic [7:0] PITCH_FIRST   = 8'hE0;
    localparam logic [7:0] SYSTEM_FIRST  = 8'hF0;

    // Data bytes after each system status F0..F7; a negative count means random.
    localparam int SYS_DATA_BYTES [8] = '{-1, 1, 2, 1, -1, -1, -1, -1};

    // Directed sequence: an orphan data byte, a note-on with a realtime byte
    // inside, a running-status note-on, a zero-velocity note-on, an
    // all-notes-off with two tracked notes and one with none, two-byte and
    // system common messages, a repeated tune request and a raw sysex run.
    localparam logic [7:0] DIRECTED_SEQ [DIRECTED_LEN] = '{
        8'h00,
        8'h90, 8'h00, 8'hF8, 8'h7F,
        8'h7F, 8'h01,
        8'hFF,
        8'h91, 8'h40, 8'h00,
        8'hB0, 8'h7B, 8'h00,
        8'hB1, 8'h7F, 8'h00,
        8'hC5, 8'h10,
        8'hF1, 8'h20,
        8'hF2, 8'h01, 8'h02,
        8'hF6, 8'h00,
        8'hF0, 8'h12, 8'hF7
    };

    logic i_clk = 1'b0;
    logic i_rst_n;
    bit   idle_on;
    bit   hold_req;
    bit   hold_done;
    int   fail_count;
    int   pending;
    int   items_sent;
    int   quiet_cycles;

    mmf_in_if  in_ch ();
    mmf_out_if out_ch ();
    mmf_cfg_if cfg_ch ();

    midi_message_filter_note_tracking_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    mmf_note_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 i_clk = ~i_clk;

    // Offer one byte, with an occasional gap first, and wait for its transfer.
    task automatic offer_midi_byte(input logic [7:0] value);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 4);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.byte_in <= value;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic write_emulate(input logic enable);
        cfg_ch.valid                 <= 1'b1;
        cfg_ch.emulate_all_notes_off <= enable;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Stop offering, wait for every expected byte, then let the filter settle.
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One random message with running-status repeats, or a single stray byte.
    task automatic send_random_message();
        int         pick;
        int         repeats;
        int         n_data;
        logic [7:0] status;
        logic       is_note_on;
        logic       is_ctrl;
        pick       = $urandom_range(0, 99);
        is_note_on = 1'b0;
        is_ctrl    = 1'b0;
        if (pick < 8) begin
            offer_midi_byte(8'($urandom_range(REALTIME_MIN, 8'hFF)));
        end else if (pick < 16) begin
            offer_midi_byte(8'($urandom_range(0, 255)));
        end else begin
            if (pick < 45) begin
                status     = {KIND_NOTE_ON, 4'($urandom_range(0, 3))};
                is_note_on = 1'b1;
            end else if (pick < 58) begin
                status  = {KIND_CTRL, 4'($urandom_range(0, 3))};
                is_ctrl = 1'b1;
            end else if (pick < 85) begin
                status = 8'($urandom_range(8'h80, 8'hEF));
            end else begin
                status = 8'($urandom_range(SYSTEM_FIRST, 8'hF7));
            end
            if (status >= SYSTEM_FIRST) begin
                n_data = SYS_DATA_BYTES[status - SYSTEM_FIRST];
                if (n_data < 0) n_data = $urandom_range(0, 2);
            end else if (status >= PROGRAM_FIRST && status < PITCH_FIRST) begin
                n_data = 1;
            end else begin
                n_data = 2;
            end
            offer_midi_byte(status);
            repeats = $urandom_range(1, 4);
            for (int k = 0; k < repeats; k++) begin
                if ($urandom_range(0, 9) == 0) begin
                    offer_midi_byte(8'($urandom_range(REALTIME_MIN, 8'hFF)));
                end
                if (n_data >= 1) begin
                    if (is_ctrl && $urandom_range(0, 1) == 1) begin
                        offer_midi_byte(8'($urandom_range(CC_ALL_OFF_LO, CC_ALL_OFF_HI)));
                    end else begin
                        offer_midi_byte(8'($urandom_range(0, 8'h7F)));
                    end
                end
                // Now and then the second data byte goes missing.
                if (n_data >= 2 && $urandom_range(0, 11) != 0) begin
                    if (is_note_on && $urandom_range(0, 4) == 0) begin
                        offer_midi_byte(8'h00);
                    end else begin
                        offer_midi_byte(8'($urandom_range(1, 8'h7F)));
                    end
                end
            end
        end
    endtask

    task automatic random_traffic(input int count, input bit with_hold);
        int start_count;
        start_count = items_sent;
        while (items_sent < start_count + count) begin
            if (with_hold && !hold_done && items_sent >= start_count + 10) begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            send_random_message();
        end
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin : receiver
        int gap;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                out_ch.ready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 4);
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: ends the run after too many cycles without any transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("tb_top NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus and verdict.
    initial begin : stimulus
        i_rst_n                      <= 1'b0;
        in_ch.valid                  <= 1'b0;
        in_ch.byte_in                <= 8'h00;
        cfg_ch.valid                 <= 1'b0;
        cfg_ch.emulate_all_notes_off <= 1'b0;
        idle_on   = 1'b1;
        hold_req  = 1'b0;
        hold_done = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed sequence with note tracking on.
        write_emulate(1'b1);
        for (int k = 0; k < DIRECTED_LEN; k++) begin
            offer_midi_byte(DIRECTED_SEQ[k]);
        end
        drain_results();

        // Plain filtering, then tracking again with the long hold-off.
        write_emulate(1'b0);
        random_traffic(25, 1'b0);
        drain_results();
        write_emulate(1'b1);
        random_traffic(30, 1'b1);

        // Final stretch at full rate on both sides.
        idle_on = 1'b0;
        random_traffic(15, 1'b0);
        drain_results();

        if (fail_count == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

### midi_message_filter_note_tracking_top.f
rtl/mmf_pkg.sv
rtl/mmf_in_if.sv
rtl/mmf_out_if.sv
rtl/mmf_cfg_if.sv
rtl/mmf_ctrl.sv
rtl/mmf_datapath.sv
rtl/midi_message_filter_note_tracking_top.sv
verif/mmf_note_checker.sv
verif/tb_top.sv
